@@ rtl/codepoint_to_glyph_range_lookup_assert.svh @@
// Assertion macros shared by the glyph lookup RTL.
`ifndef CODEPOINT_TO_GLYPH_RANGE_LOOKUP_ASSERT_SVH
`define CODEPOINT_TO_GLYPH_RANGE_LOOKUP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CGL_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Implication checked in the next cycle.
`define CGL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ rtl/cgl_pkg.sv @@
// ----------------------------------------------------------------------------
// cgl_pkg
// Types and constants for the codepoint to glyph lookup.
// ----------------------------------------------------------------------------
package cgl_pkg;
    localparam int MAX_RANGES = 16;
    localparam int RIDX_W = $clog2(MAX_RANGES);
    localparam int LIST_DEPTH = 4096;
    localparam int LIST_AW = $clog2(LIST_DEPTH);
    localparam int OFFSET_DEPTH = 4096;
    localparam int OFF_AW = $clog2(OFFSET_DEPTH);

    localparam logic [1:0] CMD_RANGE = 2'd0;
    localparam logic [1:0] CMD_LIST = 2'd1;
    localparam logic [1:0] CMD_OFFSET = 2'd2;
    localparam logic [1:0] CMD_LOOKUP = 2'd3;

    localparam logic [2:0] ST_FOUND = 3'd0;
    localparam logic [2:0] ST_NOT_COVERED = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_FORMAT = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    localparam logic [2:0] FLD_START = 3'd0;
    localparam logic [2:0] FLD_LENGTH = 3'd1;
    localparam logic [2:0] FLD_FIRST = 3'd2;
    localparam logic [2:0] FLD_LLEN = 3'd3;
    localparam logic [2:0] FLD_KIND = 3'd4;
    localparam logic [2:0] FLD_LBASE = 3'd5;
    localparam logic [2:0] FLD_OBASE = 3'd6;
    localparam logic [2:0] FLD_FLAGS = 3'd7;

    localparam logic [1:0] REG_RANGE_COUNT = 2'd0;
    localparam logic [1:0] REG_COMPRESSED = 2'd1;

    typedef struct packed {
        logic [20:0] start;
        logic [15:0] length;
        logic [15:0] first;
        logic [12:0] llen;
        logic [1:0]  kind;
        logic [11:0] lbase;
        logic [11:0] obase;
        logic [1:0]  flags;
    } range_t;

    localparam int RANGE_W = $bits(range_t);
endpackage

@@ rtl/codepoint_to_glyph_range_lookup.sv @@
// ----------------------------------------------------------------------------
// codepoint_to_glyph_range_lookup
// Character map lookup: codepoint to glyph index through a range table.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit first)
// s_axis  | in  | command, range_index, range_field, mem_address, value, codepoint
// m_axis  | out | status, glyph_id
// apb     | cfg | 0: range_count, 1: compressed_format
// List and offset writes are answered via the write-done register; range
// field writes wait until the table is no longer busy, as the entry is
// read and then written back. A lookup reads and checks each range in
// turn, takes a probe and a check state per binary search step, then the
// final list and offset reads where needed; all RAMs have registered reads.
// Reset clears the range table through valid bits; the list and offset
// memories are not cleared. One request is in flight at a time; the next
// request is taken only once the previous result has been accepted.
module codepoint_to_glyph_range_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], range_index[5:2], range_field[8:6], mem_address[20:9],
    // value[41:21], codepoint[62:42], zero pad [63]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], glyph_id[20:3], zero pad [23:21]
    output logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cgl_pkg::*;

    logic [1:0]  in_cmd;
    logic [3:0]  in_ridx;
    logic [2:0]  in_field;
    logic [11:0] in_addr;
    logic [20:0] in_value;
    logic [20:0] in_cp;
    logic        acc;
    logic        rc_reg_wr;
    logic [4:0]  range_count_reg;
    logic        compressed_reg;
    logic        tbl_wr, tbl_busy, rd_en, lk_busy, lk_done;
    logic [RIDX_W-1:0] rd_idx;
    range_t      entry;
    logic [LIST_AW-1:0] list_raddr;
    logic [OFF_AW-1:0]  off_raddr;
    logic [15:0] list_q, off_q;
    logic [2:0]  lk_status;
    logic [17:0] lk_gid;
    logic        wr_done_reg;
    logic        ovalid_reg;
    logic [23:0] odata_reg;
    logic        pend_reg;

    assign in_cmd = s_axis_tdata[1:0];
    assign in_ridx = s_axis_tdata[5:2];
    assign in_field = s_axis_tdata[8:6];
    assign in_addr = s_axis_tdata[20:9];
    assign in_value = s_axis_tdata[41:21];
    assign in_cp = s_axis_tdata[62:42];

    // A new request waits until the previous result has left the core.
    assign s_axis_tready = !pend_reg && !ovalid_reg;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign tbl_wr = acc && (in_cmd == CMD_RANGE) && (32'(in_ridx) < MAX_RANGES);

    assign pready = 1'b1;
    assign rc_reg_wr = psel && penable && pwrite;
    always_comb
    begin
        case (paddr[2])
            REG_RANGE_COUNT[0]: prdata = {27'd0, range_count_reg};
            default:            prdata = {31'd0, compressed_reg};
        endcase
        if (paddr[1:0] != 2'd0)
        begin
            prdata = '0;
        end
    end

    cgl_range_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_wr),
        .wr_idx   (RIDX_W'(in_ridx)),
        .wr_field (in_field),
        .wr_value (in_value),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_entry (entry),
        .busy     (tbl_busy)
    );

    cgl_ram #(.WIDTH(16), .DEPTH(LIST_DEPTH)) u_list (
        .clk   (clk),
        .we    (acc && in_cmd == CMD_LIST),
        .waddr (LIST_AW'(in_addr)),
        .wdata (in_value[15:0]),
        .raddr (list_raddr),
        .rdata (list_q)
    );

    cgl_ram #(.WIDTH(16), .DEPTH(OFFSET_DEPTH)) u_off (
        .clk   (clk),
        .we    (acc && in_cmd == CMD_OFFSET),
        .waddr (OFF_AW'(in_addr)),
        .wdata (in_value[15:0]),
        .raddr (off_raddr),
        .rdata (off_q)
    );

    cgl_lookup_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (acc && in_cmd == CMD_LOOKUP),
        .codepoint         (in_cp),
        .range_count       (range_count_reg),
        .compressed_format (compressed_reg),
        .rd_en             (rd_en),
        .rd_idx            (rd_idx),
        .entry             (entry),
        .list_raddr        (list_raddr),
        .list_q            (list_q),
        .off_raddr         (off_raddr),
        .off_q             (off_q),
        .done              (lk_done),
        .status            (lk_status),
        .glyph_id          (lk_gid),
        .busy              (lk_busy)
    );

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_count_reg <= '0;
            compressed_reg <= 1'b0;
            pend_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            wr_done_reg <= 1'b0;
        end
        else
        begin
            if (rc_reg_wr && paddr == 3'd0)
            begin
                range_count_reg <= pwdata[4:0];
            end
            if (rc_reg_wr && paddr == 3'd4)
            begin
                compressed_reg <= pwdata[0];
            end
            // A range field write holds here until its write-back is finished.
            wr_done_reg <= (acc && in_cmd != CMD_LOOKUP) || (wr_done_reg && tbl_busy);
            if (acc)
            begin
                pend_reg <= 1'b1;
            end
            else if ((wr_done_reg && !tbl_busy) || lk_done)
            begin
                pend_reg <= 1'b0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            if ((wr_done_reg && !tbl_busy) || lk_done)
            begin
                ovalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_done_reg && !tbl_busy)
        begin
            odata_reg <= {3'd0, 18'd0, ST_WRITE};
        end
        else if (lk_done)
        begin
            odata_reg <= {3'd0, lk_gid, lk_status};
        end
    end

    `include "codepoint_to_glyph_range_lookup_assert.svh"
    `CGL_ASSERT_IMP(a_no_overrun, clk, rst_n, lk_done, !ovalid_reg)
    `CGL_ASSERT_IMP(a_lk_pend, clk, rst_n, lk_busy, pend_reg)
    `CGL_ASSERT_NEXT(a_acc_pend, clk, rst_n, acc, pend_reg)
endmodule

@@ rtl/cgl_ram.sv @@
// ----------------------------------------------------------------------------
// cgl_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module cgl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/cgl_range_table.sv @@
// ----------------------------------------------------------------------------
// cgl_range_table
// Range entry store: one RAM, read-modify-write of single fields, with
// valid bits so that entries never written read as zero.
// ----------------------------------------------------------------------------
module cgl_range_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [cgl_pkg::RIDX_W-1:0] wr_idx,
    input  logic [2:0]                wr_field,
    input  logic [20:0]               wr_value,
    input  logic                      rd_en,
    input  logic [cgl_pkg::RIDX_W-1:0] rd_idx,
    output cgl_pkg::range_t           rd_entry,
    output logic                      busy
);
    import cgl_pkg::*;

    logic [MAX_RANGES-1:0] valid_reg, valid_next;
    logic                  pend_reg, pend_next;
    logic [RIDX_W-1:0]     pidx_reg, pidx_next;
    logic [2:0]            pfield_reg, pfield_next;
    logic [20:0]           pval_reg, pval_next;
    logic                  rvalid_reg;
    logic [RIDX_W-1:0]     ridx_reg;
    logic [RANGE_W-1:0]    ram_q;
    range_t                cur, upd;
    logic                  we;
    logic [RIDX_W-1:0]     raddr;

    // A field write first reads the entry, then writes it back in the next cycle.
    assign raddr = wr_en ? wr_idx : rd_idx;
    assign we = pend_reg;
    assign busy = pend_reg;
    assign cur = range_t'(valid_reg[ridx_reg] ? ram_q : '0);
    assign rd_entry = cur;

    always_comb
    begin
        upd = cur;
        case (pfield_reg)
            FLD_START:  upd.start = pval_reg;
            FLD_LENGTH: upd.length = pval_reg[15:0];
            FLD_FIRST:  upd.first = pval_reg[15:0];
            FLD_LLEN:   upd.llen = pval_reg[12:0];
            FLD_KIND:   upd.kind = pval_reg[1:0];
            FLD_LBASE:  upd.lbase = pval_reg[11:0];
            FLD_OBASE:  upd.obase = pval_reg[11:0];
            default:    upd.flags = pval_reg[1:0];
        endcase
        pend_next = wr_en;
        pidx_next = wr_en ? wr_idx : pidx_reg;
        pfield_next = wr_en ? wr_field : pfield_reg;
        pval_next = wr_en ? wr_value : pval_reg;
        valid_next = valid_reg;
        if (pend_reg)
        begin
            valid_next[pidx_reg] = 1'b1;
        end
    end

    cgl_ram #(.WIDTH(RANGE_W), .DEPTH(MAX_RANGES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (pidx_reg),
        .wdata (RANGE_W'(upd)),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            pend_reg <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg <= pend_next;
            rvalid_reg <= wr_en | rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        pfield_reg <= pfield_next;
        pval_reg <= pval_next;
        ridx_reg <= raddr;
    end

    `include "codepoint_to_glyph_range_lookup_assert.svh"
    `CGL_ASSERT_NEXT(a_wr_pend, clk, rst_n, wr_en, pend_reg)
    `CGL_ASSERT_IMP(a_pend_read, clk, rst_n, pend_reg, rvalid_reg)
    `CGL_ASSERT_NEXT(a_valid_set, clk, rst_n, pend_reg, valid_reg[$past(pidx_reg)])
endmodule

@@ rtl/cgl_lookup_ctrl.sv @@
// ----------------------------------------------------------------------------
// cgl_lookup_ctrl
// Sequencer: range scan, binary search in the code list, offset fetch.
// ----------------------------------------------------------------------------
module cgl_lookup_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [20:0]                 codepoint,
    input  logic [4:0]                  range_count,
    input  logic                        compressed_format,
    output logic                        rd_en,
    output logic [cgl_pkg::RIDX_W-1:0]  rd_idx,
    input  cgl_pkg::range_t             entry,
    output logic [cgl_pkg::LIST_AW-1:0] list_raddr,
    input  logic [15:0]                 list_q,
    output logic [cgl_pkg::OFF_AW-1:0]  off_raddr,
    input  logic [15:0]                 off_q,
    output logic                        done,
    output logic [2:0]                  status,
    output logic [17:0]                 glyph_id,
    output logic                        busy
);
    import cgl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RREAD = 3'd1;
    localparam logic [2:0] S_RCHK = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_PCHK = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;
    localparam logic [2:0] S_OFF = 3'd6;

    logic [2:0]   state_reg, state_next;
    logic [20:0]  cp_reg, cp_next;
    logic [8:0]   r_reg, r_next;
    logic [8:0]   n_reg, n_next;
    range_t       ent_reg, ent_next;
    logic [15:0]  rel_reg, rel_next;
    logic [12:0]  lo_reg, lo_next;
    logic [12:0]  hi_reg, hi_next;
    logic [12:0]  probe;
    logic [15:0]  pos_reg, pos_next;
    logic         done_next;
    logic [2:0]   status_reg, status_next;
    logic [17:0]  gid_reg, gid_next;
    logic [21:0]  diff;
    logic [17:0]  gsum;
    logic [17:0]  gfinal;
    logic [15:0]  offadd;
    logic         dense;

    assign probe = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign diff = {1'b0, cp_reg} - {1'b0, entry.start};
    assign dense = ~ent_reg.kind[0];
    assign gsum = 18'(ent_reg.first) + 18'(pos_reg);
    assign offadd = (ent_reg.kind == 2'd1) ? off_q : {8'd0, off_q[7:0]};
    assign gfinal = gsum + 18'(offadd);
    assign rd_en = (state_reg == S_RREAD);
    assign rd_idx = r_reg[RIDX_W-1:0];
    assign list_raddr = LIST_AW'(ent_reg.lbase + ((state_reg == S_FINAL) ? lo_reg[11:0]
                                                                          : probe[11:0]));
    assign off_raddr = OFF_AW'(ent_reg.obase + pos_reg[11:0]);
    assign busy = (state_reg != S_IDLE);
    assign status = status_reg;
    assign glyph_id = gid_reg;

    always_comb
    begin
        state_next = state_reg;
        cp_next = cp_reg;
        r_next = r_reg;
        n_next = n_reg;
        ent_next = ent_reg;
        rel_next = rel_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        pos_next = pos_reg;
        done_next = 1'b0;
        status_next = status_reg;
        gid_next = gid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cp_next = codepoint;
                    r_next = '0;
                    n_next = (range_count > 5'(MAX_RANGES)) ? 9'(MAX_RANGES) : 9'(range_count);
                    gid_next = '0;
                    if (compressed_format)
                    begin
                        status_next = ST_FORMAT;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_RREAD;
                    end
                end
            end
            S_RREAD:
            begin
                if (r_reg >= n_reg)
                begin
                    status_next = ST_NOT_COVERED;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RCHK;
                end
            end
            S_RCHK:
            begin
                ent_next = entry;
                rel_next = diff[15:0];
                r_next = r_reg + 9'd1;
                state_next = S_RREAD;
                if (!diff[21] && diff[20:0] < {5'd0, entry.length})
                begin
                    if (!entry.kind[0])
                    begin
                        pos_next = diff[15:0];
                        hi_next = '0;
                        state_next = entry.flags[1] ? S_OFF : S_FINAL;
                    end
                    else if (!entry.flags[0])
                    begin
                        status_next = ST_REJECTED;
                        done_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        lo_next = '0;
                        hi_next = entry.llen;
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                // List read address for the probe is presented this cycle.
                if (lo_reg < hi_reg)
                begin
                    state_next = S_PCHK;
                end
                else if (lo_reg >= ent_reg.llen)
                begin
                    state_next = S_RREAD;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_PCHK:
            begin
                if (list_q < rel_reg)
                begin
                    lo_next = probe + 13'd1;
                end
                else
                begin
                    hi_next = probe;
                end
                state_next = S_PROBE;
            end
            S_FINAL:
            begin
                // Dense: plain result; sparse: the list word at lower is read, then checked on revisit.
                if (dense)
                begin
                    gid_next = gsum;
                    status_next = (gsum == '0) ? ST_REJECTED : ST_FOUND;
                    if (gsum == '0)
                    begin
                        gid_next = '0;
                    end
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FINAL;
                    if (pos_reg != {3'd0, lo_reg} || hi_reg != 13'h1fff)
                    begin
                        // first visit: the read of the list word is in flight
                        pos_next = {3'd0, lo_reg};
                        hi_next = 13'h1fff;
                    end
                    else if (list_q != rel_reg)
                    begin
                        state_next = S_RREAD;
                    end
                    else if (ent_reg.flags[1])
                    begin
                        state_next = S_OFF;
                    end
                    else
                    begin
                        status_next = (gsum == '0) ? ST_REJECTED : ST_FOUND;
                        gid_next = (gsum == '0) ? '0 : gsum;
                        done_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_OFF:
            begin
                // The offset word read address is held; the data is valid on revisit.
                if (hi_reg != 13'h1ffe)
                begin
                    hi_next = 13'h1ffe;
                end
                else
                begin
                    status_next = (gfinal == '0) ? ST_REJECTED : ST_FOUND;
                    gid_next = (gfinal == '0) ? '0 : gfinal;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg <= cp_next;
        r_reg <= r_next;
        n_reg <= n_next;
        ent_reg <= ent_next;
        rel_reg <= rel_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        pos_reg <= pos_next;
        status_reg <= status_next;
        gid_reg <= gid_next;
    end

    `include "codepoint_to_glyph_range_lookup_assert.svh"
    `CGL_ASSERT_IMP(a_start_idle, clk, rst_n, start, state_reg == S_IDLE)
    `CGL_ASSERT_NEXT(a_done_idle, clk, rst_n, done_next, state_reg == S_IDLE)
    `CGL_ASSERT_IMP(a_found_nz, clk, rst_n, done && status_reg == ST_FOUND, gid_reg != '0)
endmodule

@@ bench/codepoint_to_glyph_range_lookup_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codepoint_to_glyph_range_lookup_tb
// Self-checking bench for the character map lookup. Range tables and sorted
// code lists are loaded through write requests, then lookups aimed at the
// ranges and at random codepoints are checked against a shadow copy of the
// tables kept in the bench, under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module codepoint_to_glyph_range_lookup_tb;
    import cgl_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [17:0] glyph;
    } glyph_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    codepoint_to_glyph_range_lookup uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow of the range table, memories and registers.
    logic [20:0] sh_start [MAX_RANGES];
    logic [15:0] sh_len   [MAX_RANGES];
    logic [15:0] sh_first [MAX_RANGES];
    logic [12:0] sh_llen  [MAX_RANGES];
    logic [1:0]  sh_kind  [MAX_RANGES];
    logic [11:0] sh_lbase [MAX_RANGES];
    logic [11:0] sh_obase [MAX_RANGES];
    logic [1:0]  sh_flags [MAX_RANGES];
    logic [15:0] code_mem [LIST_DEPTH];
    bit          code_written [LIST_DEPTH];
    logic [15:0] offs_mem [OFFSET_DEPTH];
    bit          offs_written [OFFSET_DEPTH];
    logic [4:0]  sh_count = '0;
    logic        sh_compressed = 1'b0;

    logic [63:0] pending_reqs [$];
    glyph_res_t  expected_glyphs [$];
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          mismatches = 0;

    // Full lookup on the shadow state; touches_unwritten flags any read of a
    // memory word that was never loaded.
    function automatic void lookup_glyph(input logic [20:0] cp, output logic [2:0] st,
                                         output logic [17:0] gid,
                                         output bit touches_unwritten);
        int          n;
        int          lo;
        int          hi;
        int          pr;
        logic [20:0] rel;
        logic [31:0] g;
        logic [11:0] a;
        touches_unwritten = 0;
        gid = '0;
        st = ST_NOT_COVERED;
        if (sh_compressed)
        begin
            st = ST_FORMAT;
            return;
        end
        n = (sh_count > MAX_RANGES) ? MAX_RANGES : sh_count;
        for (int r = 0; r < n; r++)
        begin
            if (cp < sh_start[r])
                continue;
            rel = cp - sh_start[r];
            if (rel >= sh_len[r])
                continue;
            if (!sh_kind[r][0])
            begin
                g = sh_first[r] + rel;
                if (sh_flags[r][1])
                begin
                    a = sh_obase[r] + rel[11:0];
                    if (!offs_written[a])
                        touches_unwritten = 1;
                    g += offs_mem[a][7:0];
                end
            end
            else
            begin
                if (!sh_flags[r][0])
                begin
                    st = ST_REJECTED;
                    return;
                end
                lo = 0;
                hi = sh_llen[r];
                while (lo < hi)
                begin
                    pr = lo + (hi - lo) / 2;
                    a = sh_lbase[r] + pr[11:0];
                    if (!code_written[a])
                        touches_unwritten = 1;
                    if (code_mem[a] < rel)
                        lo = pr + 1;
                    else
                        hi = pr;
                end
                if (lo >= sh_llen[r])
                    continue;
                a = sh_lbase[r] + lo[11:0];
                if (!code_written[a])
                    touches_unwritten = 1;
                if (code_mem[a] != rel)
                    continue;
                g = sh_first[r] + lo;
                if (sh_flags[r][1])
                begin
                    a = sh_obase[r] + lo[11:0];
                    if (!offs_written[a])
                        touches_unwritten = 1;
                    g += (sh_kind[r] == 2'd3) ? offs_mem[a][7:0] : offs_mem[a];
                end
            end
            if (g[17:0] == '0)
            begin
                st = ST_REJECTED;
                return;
            end
            gid = g[17:0];
            st = ST_FOUND;
            return;
        end
    endfunction

    function automatic bit lookup_safe(input logic [20:0] cp);
        logic [2:0]  st;
        logic [17:0] gid;
        bit          bad;
        lookup_glyph(cp, st, gid, bad);
        return !bad;
    endfunction

    task automatic queue_req(input logic [1:0] cmd, input logic [3:0] ri,
                             input logic [2:0] fld, input logic [11:0] addr,
                             input logic [20:0] val, input logic [20:0] cp);
        glyph_res_t res;
        bit         bad;
        res.status = ST_WRITE;
        res.glyph = '0;
        case (cmd)
            CMD_RANGE:
                case (fld)
                    FLD_START:  sh_start[ri] = val;
                    FLD_LENGTH: sh_len[ri] = val[15:0];
                    FLD_FIRST:  sh_first[ri] = val[15:0];
                    FLD_LLEN:   sh_llen[ri] = val[12:0];
                    FLD_KIND:   sh_kind[ri] = val[1:0];
                    FLD_LBASE:  sh_lbase[ri] = val[11:0];
                    FLD_OBASE:  sh_obase[ri] = val[11:0];
                    default:    sh_flags[ri] = val[1:0];
                endcase
            CMD_LIST:
            begin
                code_mem[addr] = val[15:0];
                code_written[addr] = 1;
            end
            CMD_OFFSET:
            begin
                offs_mem[addr] = val[15:0];
                offs_written[addr] = 1;
            end
            default:
                lookup_glyph(cp, res.status, res.glyph, bad);
        endcase
        pending_reqs.push_back({1'b0, cp, val, addr, fld, ri, cmd});
        expected_glyphs.push_back(res);
    endtask

    // Junk above the field width checks that the block masks the value.
    task automatic wr_range(input int r, input logic [2:0] fld, input logic [20:0] val);
        int          w;
        logic [20:0] v;
        case (fld)
            FLD_START:              w = 21;
            FLD_LENGTH, FLD_FIRST:  w = 16;
            FLD_LLEN:               w = 13;
            FLD_LBASE, FLD_OBASE:   w = 12;
            default:                w = 2;
        endcase
        v = (21'($urandom) << w) | val;
        queue_req(CMD_RANGE, r[3:0], fld, $urandom, v, $urandom);
    endtask

    task automatic wr_code(input logic [11:0] a, input logic [15:0] v);
        queue_req(CMD_LIST, $urandom, $urandom, a, {5'($urandom), v}, $urandom);
    endtask

    task automatic wr_offs(input logic [11:0] a, input logic [15:0] v);
        queue_req(CMD_OFFSET, $urandom, $urandom, a, {5'($urandom), v}, $urandom);
    endtask

    task automatic look(input logic [20:0] cp);
        queue_req(CMD_LOOKUP, $urandom, $urandom, $urandom, $urandom, cp);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_glyphs.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        wait_drained();
        repeat (100) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(idx * 4);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_RANGE_COUNT)
            sh_count = val[4:0];
        else
            sh_compressed = val[0];
        @(posedge clk);
    endtask

    // Loads every range entry with a coherent layout: sorted code lists and
    // offsets for each entry that claims them.
    task automatic build_table();
        logic [11:0] lb;
        logic [11:0] ob;
        logic [1:0]  kind;
        logic [1:0]  flags;
        int          len;
        int          ll;
        int          code;
        int          cnt;
        for (int r = 0; r < MAX_RANGES; r++)
        begin
            kind = $urandom_range(0, 3);
            flags = $urandom_range(0, 3);
            len = $urandom_range(0, 16);
            ll = kind[0] ? $urandom_range(0, 6) : $urandom_range(0, 3);
            lb = $urandom;
            ob = $urandom;
            if ($urandom_range(0, 9) == 0)
                wr_range(r, FLD_START, 21'h10FFFF - $urandom_range(0, 20));
            else
                wr_range(r, FLD_START, r * 32 + $urandom_range(0, 24));
            wr_range(r, FLD_LENGTH, len);
            wr_range(r, FLD_FIRST, ($urandom_range(0, 9) == 0) ? 0 : 16'($urandom));
            wr_range(r, FLD_LLEN, ll);
            wr_range(r, FLD_KIND, kind);
            wr_range(r, FLD_LBASE, lb);
            wr_range(r, FLD_OBASE, ob);
            wr_range(r, FLD_FLAGS, flags);
            if (kind[0] && flags[0])
            begin
                code = $urandom_range(0, 2);
                for (int k = 0; k < ll; k++)
                begin
                    wr_code(lb + k, code);
                    code += $urandom_range(1, 4);
                end
            end
            if (flags[1])
            begin
                cnt = kind[0] ? ll : len;
                for (int k = 0; k < cnt; k++)
                    wr_offs(ob + k, $urandom);
            end
        end
    endtask

    task automatic random_reqs(input int n);
        int          p;
        int          r;
        bit          sent;
        logic [20:0] cp;
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 5)
                queue_req($urandom_range(0, 2), $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            else if (p < 20)
            begin
                if (p[0])
                    wr_code($urandom, $urandom);
                else
                    wr_offs($urandom, $urandom);
            end
            else
            begin
                sent = 0;
                for (int t = 0; t < 8 && !sent; t++)
                begin
                    r = $urandom_range(0, MAX_RANGES - 1);
                    if ($urandom_range(0, 6) == 0)
                        cp = $urandom_range(0, 1114111);
                    else
                        cp = sh_start[r] + $urandom_range(0, sh_len[r] + 1);
                    if (lookup_safe(cp))
                    begin
                        look(cp);
                        sent = 1;
                    end
                end
                if (!sent)
                    wr_offs($urandom, $urandom);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                void'(pending_reqs.pop_front());
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= snd_idle)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_reqs[0];
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        glyph_res_t got;
        glyph_res_t want;
        got.status = m_axis_tdata[2:0];
        got.glyph = m_axis_tdata[20:3];
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_glyphs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d glyph %0d",
                             got.status, got.glyph);
            end
            else
            begin
                want = expected_glyphs.pop_front();
                if (got.status !== want.status || got.glyph !== want.glyph)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d glyph %0d, got status %0d glyph %0d",
                                 want.status, want.glyph, got.status, got.glyph);
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        for (int r = 0; r < MAX_RANGES; r++)
        begin
            sh_start[r] = '0; sh_len[r] = '0; sh_first[r] = '0; sh_llen[r] = '0;
            sh_kind[r] = '0; sh_lbase[r] = '0; sh_obase[r] = '0; sh_flags[r] = '0;
        end
        for (int a = 0; a < LIST_DEPTH; a++)
        begin
            code_mem[a] = '0;
            code_written[a] = 0;
        end
        for (int a = 0; a < OFFSET_DEPTH; a++)
        begin
            offs_mem[a] = '0;
            offs_written[a] = 0;
        end
        snd_idle = 25;
        rcv_idle = 67;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no ranges in use nothing is covered.
        look(21'd0);
        look(21'd1114111);
        reg_write(REG_RANGE_COUNT, 32'd16);
        wr_range(0, FLD_START, 21'h41);
        wr_range(0, FLD_LENGTH, 26);
        wr_range(0, FLD_FIRST, 3);
        look(21'h41);
        look(21'h5A);
        look(21'h5B);
        look(21'h40);
        // A first glyph of zero at relative code zero gives glyph zero.
        wr_range(0, FLD_FIRST, 0);
        look(21'h41);
        // Sparse range that has no code list.
        wr_range(1, FLD_START, 21'h1FFFFF);
        wr_range(1, FLD_LENGTH, 16'hFFFF);
        wr_range(1, FLD_KIND, 1);
        look(21'h1FFFFF);
        wr_range(1, FLD_KIND, 3);
        look(21'h1FFFFF);
        reg_write(REG_COMPRESSED, 32'd1);
        look(21'h5A);
        queue_req(CMD_RANGE, 4'd15, FLD_FLAGS, 12'hFFF, 21'h1FFFFF, 21'h1FFFFF);
        reg_write(REG_COMPRESSED, 32'd0);

        build_table();
        random_reqs(40);
        // Sender holds back until the block has answered everything.
        wait_drained();
        random_reqs(30);

        reg_write(REG_RANGE_COUNT, 32'd5);
        snd_idle = 67;
        rcv_idle = 25;
        random_reqs(30);
        reg_write(REG_COMPRESSED, 32'd1);
        random_reqs(10);
        reg_write(REG_COMPRESSED, 32'd0);
        reg_write(REG_RANGE_COUNT, 32'd0);
        random_reqs(5);
        reg_write(REG_RANGE_COUNT, 32'd16);
        snd_idle = 0;
        rcv_idle = 0;
        build_table();
        random_reqs(45);

        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_glyphs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/cgl_pkg.sv
rtl/cgl_ram.sv
rtl/cgl_range_table.sv
rtl/cgl_lookup_ctrl.sv
rtl/codepoint_to_glyph_range_lookup.sv
bench/codepoint_to_glyph_range_lookup_tb.sv
